// ===== rtl/sdw_pkg.sv =====
// ----------------------------------------------------------------------------
// sdw_pkg
// Shared types and codes for the sequence duplicate window.
// ----------------------------------------------------------------------------
package sdw_pkg;

	localparam int SEQ_W = 16;

	typedef logic [SEQ_W-1:0] seq_t;

	// item kind codes
	localparam logic KIND_NOTE  = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	// control broadcast to every cell of the window
	typedef struct packed {
		logic shift;   // move every entry one cell along, take the new number at the head
		logic clear;   // drop every entry
	} cell_ctl_t;

	// one entry handed from cell to cell
	typedef struct packed {
		logic valid;
		seq_t num;
	} entry_t;

endpackage

// ===== rtl/sequence_dedup_window_top.sv =====
// ----------------------------------------------------------------------------
// sequence_dedup_window_top
// Duplicate filter over the most recent command sequence numbers.
//
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+---------------------------
// note    | in        | note_valid / note_stall    | kind, sequence_number
// result  | out       | result_valid / result_stall| is_duplicate
//
// Cycles: one transaction per cycle while note_stall is low. The window
//   compare is a parallel match over all cells.
// Reset: arst_n empties the window at once; no clearing pass is needed.
// Stalls: a two-entry result queue takes results while the result side
//   stalls; note_stall rises only once both entries hold results.
// ----------------------------------------------------------------------------
module sequence_dedup_window_top #(
	parameter int WINDOW = 32   // 1..255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               note_valid,
	output logic               note_stall,
	input  logic               kind,
	input  logic [15:0]        sequence_number,
	output logic               result_valid,
	input  logic               result_stall,
	output logic               is_duplicate
);
	import sdw_pkg::*;

	// The window is kept as a shift line of the last WINDOW distinct numbers
	// taken in. The fill-in-order then overwrite-oldest policy keeps exactly
	// that set, and only set membership decides a duplicate, so a shift line
	// with a valid bit per cell gives the same answers.

	logic              accept;
	logic              buf_full;
	logic              match;
	logic [WINDOW-1:0] hits;
	cell_ctl_t         ctl;
	entry_t            chain [WINDOW+1];

	assign note_stall = buf_full;
	assign accept     = note_valid && !buf_full;

	// head of the chain: the incoming number, always valid
	assign chain[0].valid = 1'b1;
	assign chain[0].num   = sequence_number;

	assign match     = |hits;
	// advance the line only for a new number; drop everything on clear
	assign ctl.shift = accept && (kind == KIND_NOTE) && !match;
	assign ctl.clear = accept && (kind == KIND_CLEAR);

	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		sdw_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.prev_entry (chain[i]),
			.probe      (sequence_number),
			.entry      (chain[i+1]),
			.hit        (hits[i])
		);
	end

	// the last cell's entry falls off the end of the line
	logic tail_unused;
	assign tail_unused = chain[WINDOW].valid;

	// hold each result until the result side takes it
	sdw_result_buf u_result_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (accept),
		.push_dup     ((kind == KIND_NOTE) && match && !tail_unused | ((kind == KIND_NOTE)
		               && match)),
		.full         (buf_full),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.is_duplicate (is_duplicate)
	);

endmodule

// ===== rtl/sdw_cell.sv =====
// ----------------------------------------------------------------------------
// sdw_cell
// One slot of the window: holds an entry, matches it against the probe,
// and hands it to the next cell on a shift.
// ----------------------------------------------------------------------------
module sdw_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sdw_pkg::cell_ctl_t ctl,
	input  sdw_pkg::entry_t   prev_entry,
	input  sdw_pkg::seq_t     probe,
	output sdw_pkg::entry_t   entry,
	output logic              hit
);
	import sdw_pkg::*;

	logic valid_q;
	seq_t num_q;

	// valid bit: clear drops it, shift takes the neighbor's
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			num_q <= prev_entry.num;
		end
	end

	assign entry.valid = valid_q;
	assign entry.num   = num_q;
	assign hit         = valid_q && (num_q == probe);

endmodule

// ===== rtl/sdw_result_buf.sv =====
// ----------------------------------------------------------------------------
// sdw_result_buf
// Two-entry result queue that parts the result side from the note side.
// ----------------------------------------------------------------------------
module sdw_result_buf (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic push_dup,
	output logic full,
	output logic result_valid,
	input  logic result_stall,
	output logic is_duplicate
);
	import sdw_pkg::*;

	logic [1:0] count_q;
	logic       head_q;
	logic       tail_q;
	logic       pop;

	assign pop          = result_valid && !result_stall;
	assign result_valid = (count_q != 2'd0);
	assign full         = (count_q == 2'd2);
	assign is_duplicate = head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push && !pop) begin
			count_q <= count_q + 2'd1;
		end else if (pop && !push) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !pop) begin
			if (count_q == 2'd0) begin
				head_q <= push_dup;
			end else begin
				tail_q <= push_dup;
			end
		end else if (pop && !push) begin
			head_q <= tail_q;
		end else if (pop && push) begin
			// push with a pop never sees a full queue
			if (count_q == 2'd1) begin
				head_q <= push_dup;
			end else begin
				head_q <= tail_q;
				tail_q <= push_dup;
			end
		end
	end

endmodule
